// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the calendar date counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/caldc_pkg.sv =====
// Types, constants and calendar functions of the calendar date counter.
package caldc_pkg;

	localparam int YEAR_BITS_DEF  = 14;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [5:0] YEAR_MOD    = 6'd25;
	localparam logic [3:0] MONTH_FIRST = 4'd1;
	localparam logic [3:0] MONTH_FEB   = 4'd2;
	localparam logic [3:0] MONTH_LAST  = 4'd12;
	localparam logic [4:0] DAY_FIRST   = 5'd1;
	localparam logic [4:0] DAY_LAST    = 5'd31;
	localparam logic [4:0] FEB_LEAP    = 5'd29;
	localparam logic [4:0] FEB_COMMON  = 5'd28;
	localparam logic [4:0] SHORT_MONTH = 5'd30;

	// Since 1025 is a multiple of 25, 10-bit pieces of the year fold with alternating signs.
	localparam logic [11:0] FOLD_BIAS = 12'd1050;
	localparam logic [10:0] RECIP_25  = 11'd1311;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_FWD  = 2'd1,
		OP_BACK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_YEAR  = 3'd1,
		ST_BAD_MONTH = 3'd2,
		ST_BAD_DAY   = 3'd3,
		ST_LIMIT     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_CHECK,
		S_FWD,
		S_BACK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic mod_step;
		logic check;
		logic step_fwd;
		logic step_back;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mod_last;
		logic cnt_zero;
		logic fwd_limit;
		logic back_limit;
		logic out_busy;
	} sts_t;

	// Leap test from the low year bits and whether the year is a multiple of 25.
	function automatic logic is_leap(logic [3:0] ylow, logic mod25_zero);
		is_leap = (ylow[1:0] == 2'd0) && !(mod25_zero && (ylow[3:2] != 2'd0));
	endfunction

	function automatic logic [4:0] days_in(logic [3:0] m, logic leap);
		case (m)
			MONTH_FEB: days_in = leap ? FEB_LEAP : FEB_COMMON;
			4'd4, 4'd6, 4'd9, 4'd11: days_in = SHORT_MONTH;
			default: days_in = DAY_LAST;
		endcase
	endfunction

endpackage

// ===== rtl/core/caldc_ctrl.sv =====
// Controller state machine of the calendar date counter.
module caldc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         op,
	input  caldc_pkg::sts_t    sts,
	output logic               in_ready,
	output caldc_pkg::cmd_t    cmd
);

	caldc_pkg::state_t state_q;
	caldc_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= caldc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			caldc_pkg::S_IDLE: begin
				if (in_valid) begin
					case (caldc_pkg::op_t'(op))
						caldc_pkg::OP_LOAD: state_nxt = caldc_pkg::S_MOD;
						caldc_pkg::OP_FWD:  state_nxt = caldc_pkg::S_FWD;
						caldc_pkg::OP_BACK: state_nxt = caldc_pkg::S_BACK;
						default:            state_nxt = caldc_pkg::S_EMIT;
					endcase
				end
			end
			caldc_pkg::S_MOD: begin
				if (sts.mod_last) begin
					state_nxt = caldc_pkg::S_CHECK;
				end
			end
			caldc_pkg::S_CHECK: state_nxt = caldc_pkg::S_EMIT;
			caldc_pkg::S_FWD: begin
				if (sts.cnt_zero || sts.fwd_limit) begin
					state_nxt = caldc_pkg::S_EMIT;
				end
			end
			caldc_pkg::S_BACK: begin
				if (sts.cnt_zero || sts.back_limit) begin
					state_nxt = caldc_pkg::S_EMIT;
				end
			end
			caldc_pkg::S_EMIT: begin
				if (!sts.out_busy) begin
					state_nxt = caldc_pkg::S_IDLE;
				end
			end
			default: state_nxt = caldc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			caldc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			caldc_pkg::S_MOD:   cmd.mod_step = 1'b1;
			caldc_pkg::S_CHECK: cmd.check = 1'b1;
			caldc_pkg::S_FWD:   cmd.step_fwd = !sts.cnt_zero;
			caldc_pkg::S_BACK:  cmd.step_back = !sts.cnt_zero;
			caldc_pkg::S_EMIT:  cmd.emit = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/caldc_dp.sv =====
// Datapath of the calendar date counter: date registers, year remainder and output register.
module caldc_dp #(
	parameter int YEAR_BITS  = caldc_pkg::YEAR_BITS_DEF,
	parameter int COUNT_BITS = caldc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  caldc_pkg::cmd_t       cmd,
	output caldc_pkg::sts_t       sts,
	input  logic [4:0]            load_day,
	input  logic [3:0]            load_month,
	input  logic [YEAR_BITS-1:0]  load_year,
	input  logic [COUNT_BITS-1:0] step_count,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [4:0]            cur_day,
	output logic [3:0]            cur_month,
	output logic [YEAR_BITS-1:0]  cur_year,
	output logic [2:0]            status
);

	logic [4:0]            day_q;
	logic [3:0]            month_q;
	logic [YEAR_BITS-1:0]  year_q;
	logic [4:0]            ymod_q;

	logic [4:0]            ld_q;
	logic [3:0]            lm_q;
	logic [YEAR_BITS-1:0]  ly_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [11:0]           fold_q;
	logic                  phase_q;
	logic [4:0]            rem_q;
	caldc_pkg::status_t    st_q;

	logic                  out_valid_q;
	logic [4:0]            out_day_q;
	logic [3:0]            out_month_q;
	logic [YEAR_BITS-1:0]  out_year_q;
	caldc_pkg::status_t    out_st_q;

	logic [31:0] year_wide;
	logic [10:0] fold_pos;
	logic [10:0] fold_neg;
	logic [11:0] fold_nxt;
	logic [22:0] recip;
	logic [7:0]  quot;
	logic [11:0] quot25;
	logic [4:0]  rem_nxt;
	logic        leap_cur;
	logic        leap_new;
	logic [4:0]  len_cur;
	logic [3:0]  prev_month;
	logic [4:0]  len_prev;
	logic [4:0]  len_new;
	logic        fwd_limit;
	logic        back_limit;

	always_comb begin
		year_wide = 32'(ly_q);
		fold_pos  = {1'b0, year_wide[9:0]} + {1'b0, year_wide[29:20]};
		fold_neg  = {1'b0, year_wide[19:10]} + {9'd0, year_wide[31:30]};
		fold_nxt  = {1'b0, fold_pos} + caldc_pkg::FOLD_BIAS - {1'b0, fold_neg};
		recip     = 23'(fold_q) * 23'(caldc_pkg::RECIP_25);
		quot      = 8'(recip >> 15);
		quot25    = {quot, 4'd0} + {1'b0, quot, 3'd0} + {4'd0, quot};
		rem_nxt   = 5'(fold_q - quot25);
	end

	assign leap_cur   = caldc_pkg::is_leap(year_q[3:0], ymod_q == 5'd0);
	assign leap_new   = caldc_pkg::is_leap(ly_q[3:0], rem_q == 5'd0);
	assign len_cur    = caldc_pkg::days_in(month_q, leap_cur);
	assign prev_month = month_q - 4'd1;
	assign len_prev   = caldc_pkg::days_in(prev_month, leap_cur);
	assign len_new    = caldc_pkg::days_in(lm_q, leap_new);

	assign fwd_limit  = (day_q >= len_cur) && (month_q >= caldc_pkg::MONTH_LAST) &&
		(year_q == '1);
	assign back_limit = (day_q <= caldc_pkg::DAY_FIRST) &&
		(month_q <= caldc_pkg::MONTH_FIRST) && (year_q == '0);

	assign sts.mod_last   = phase_q;
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.fwd_limit  = fwd_limit;
	assign sts.back_limit = back_limit;
	assign sts.out_busy   = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ld_q    <= load_day;
			lm_q    <= load_month;
			ly_q    <= load_year;
			cnt_q   <= step_count;
			phase_q <= 1'b0;
		end else if (cmd.mod_step) begin
			if (!phase_q) begin
				fold_q <= fold_nxt;
			end else begin
				rem_q <= rem_nxt;
			end
			phase_q <= 1'b1;
		end else if (cmd.step_fwd || cmd.step_back) begin
			cnt_q <= cnt_q - COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= caldc_pkg::DAY_FIRST;
			month_q <= caldc_pkg::MONTH_FIRST;
			year_q  <= YEAR_BITS'(1);
			ymod_q  <= 5'd1;
			st_q    <= caldc_pkg::ST_OK;
		end else if (cmd.accept) begin
			st_q <= caldc_pkg::ST_OK;
		end else if (cmd.check) begin
			if (ly_q == '0) begin
				st_q <= caldc_pkg::ST_BAD_YEAR;
			end else begin
				year_q <= ly_q;
				ymod_q <= rem_q;
				if ((lm_q < caldc_pkg::MONTH_FIRST) || (lm_q > caldc_pkg::MONTH_LAST)) begin
					st_q <= caldc_pkg::ST_BAD_MONTH;
				end else begin
					month_q <= lm_q;
					if ((ld_q >= caldc_pkg::DAY_FIRST) && (ld_q <= len_new)) begin
						day_q <= ld_q;
					end else begin
						st_q <= caldc_pkg::ST_BAD_DAY;
					end
				end
			end
		end else if (cmd.step_fwd) begin
			if (fwd_limit) begin
				st_q <= caldc_pkg::ST_LIMIT;
			end else if (day_q < len_cur) begin
				day_q <= day_q + 5'd1;
			end else if (month_q < caldc_pkg::MONTH_LAST) begin
				day_q   <= caldc_pkg::DAY_FIRST;
				month_q <= month_q + 4'd1;
			end else begin
				day_q   <= caldc_pkg::DAY_FIRST;
				month_q <= caldc_pkg::MONTH_FIRST;
				year_q  <= year_q + YEAR_BITS'(1);
				ymod_q  <= (ymod_q == 5'(caldc_pkg::YEAR_MOD - 6'd1)) ? 5'd0 : ymod_q + 5'd1;
			end
		end else if (cmd.step_back) begin
			if (back_limit) begin
				st_q <= caldc_pkg::ST_LIMIT;
			end else if (day_q > caldc_pkg::DAY_FIRST) begin
				day_q <= day_q - 5'd1;
			end else if (month_q > caldc_pkg::MONTH_FIRST) begin
				month_q <= prev_month;
				day_q   <= len_prev;
			end else begin
				year_q  <= year_q - YEAR_BITS'(1);
				month_q <= caldc_pkg::MONTH_LAST;
				day_q   <= caldc_pkg::DAY_LAST;
				ymod_q  <= (ymod_q == 5'd0) ? 5'(caldc_pkg::YEAR_MOD - 6'd1) : ymod_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_day_q   <= day_q;
			out_month_q <= month_q;
			out_year_q  <= year_q;
			out_st_q    <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign cur_day   = out_day_q;
	assign cur_month = out_month_q;
	assign cur_year  = out_year_q;
	assign status    = out_st_q;

endmodule

// ===== rtl/core/calendar_date_counter.sv =====
// Top level of the calendar date counter.
// After a load request is accepted, S_MOD reduces the year modulo 25 for the leap test, then
// S_CHECK checks the fields and S_EMIT fills the output register.
// A step request moves the date by step_count days, stopping at the range limit; op 3 only emits.
// Requests are handled one at a time; the next can be taken the cycle after a result is registered.
// Reset is asynchronous and active low, sets the date to 01/01/0001 and clears the output valid.
`include "assert_macros.svh"

module calendar_date_counter #(
	parameter int YEAR_BITS  = caldc_pkg::YEAR_BITS_DEF,
	parameter int COUNT_BITS = caldc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [4:0]            load_day,
	input  logic [3:0]            load_month,
	input  logic [YEAR_BITS-1:0]  load_year,
	input  logic [COUNT_BITS-1:0] step_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [4:0]            cur_day,
	output logic [3:0]            cur_month,
	output logic [YEAR_BITS-1:0]  cur_year,
	output logic [2:0]            status
);

	caldc_pkg::cmd_t cmd;
	caldc_pkg::sts_t sts;

	caldc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	caldc_dp #(
		.YEAR_BITS  (YEAR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.load_day   (load_day),
		.load_month (load_month),
		.load_year  (load_year),
		.step_count (step_count),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.cur_day    (cur_day),
		.cur_month  (cur_month),
		.cur_year   (cur_year),
		.status     (status)
	);

	`ASSERT_HOLDS(a_month_range, clk, arst_n, !out_valid || ((cur_month >= caldc_pkg::MONTH_FIRST) && (cur_month <= caldc_pkg::MONTH_LAST)))
	`ASSERT_HOLDS(a_day_nonzero, clk, arst_n, !out_valid || (cur_day >= caldc_pkg::DAY_FIRST))
	`ASSERT_HOLDS(a_limit_at_edge, clk, arst_n, !(out_valid && (status == caldc_pkg::ST_LIMIT)) || (cur_year == '0) || (cur_year == '1))
	`ASSERT_NEXT(a_emit_shows, clk, arst_n, cmd.emit, out_valid)
	`ASSERT_HOLDS(a_idle_no_step, clk, arst_n, !in_ready || !(cmd.step_fwd || cmd.step_back || cmd.check))

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the calendar date counter: directed and random requests.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int YB = caldc_pkg::YEAR_BITS_DEF;
	localparam int CB = caldc_pkg::COUNT_BITS_DEF;
	localparam int YEAR_MAX = (1 << YB) - 1;
	localparam int COUNT_MAX = (1 << CB) - 1;

	typedef struct {
		caldc_pkg::op_t op;
		logic [4:0]     day;
		logic [3:0]     month;
		logic [YB-1:0]  year;
		logic [CB-1:0]  count;
	} request_t;

	typedef struct {
		logic [4:0]         day;
		logic [3:0]         month;
		logic [YB-1:0]      year;
		caldc_pkg::status_t status;
	} date_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [4:0] load_day = '0;
	logic [3:0] load_month = '0;
	logic [YB-1:0] load_year = '0;
	logic [CB-1:0] step_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] cur_day;
	logic [3:0] cur_month;
	logic [YB-1:0] cur_year;
	logic [2:0] status;

	request_t pending_q[$];
	date_result_t date_q[$];
	request_t held_req;
	int cal_day = 1;
	int cal_month = 1;
	int cal_year = 1;
	int send_gap = 0;
	int recv_stall = 0;
	int mismatches = 0;
	logic calm = 1'b0;

	calendar_date_counter uut (.*);

	always #5 clk = ~clk;

	function automatic int month_length(int m, int y);
		case (m)
			2: return ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic date_result_t advance_calendar(request_t r);
		date_result_t res;
		int k;
		res.status = caldc_pkg::ST_OK;
		k = 0;
		case (r.op)
			caldc_pkg::OP_LOAD: begin
				if (int'(r.year) == 0) begin
					res.status = caldc_pkg::ST_BAD_YEAR;
				end else begin
					cal_year = int'(r.year);
					if (int'(r.month) < 1 || int'(r.month) > 12) begin
						res.status = caldc_pkg::ST_BAD_MONTH;
					end else begin
						cal_month = int'(r.month);
						if (int'(r.day) >= 1 && int'(r.day) <= month_length(cal_month, cal_year))
							cal_day = int'(r.day);
						else
							res.status = caldc_pkg::ST_BAD_DAY;
					end
				end
			end
			caldc_pkg::OP_FWD: begin
				while (k < int'(r.count) && res.status == caldc_pkg::ST_OK) begin
					if (cal_day < month_length(cal_month, cal_year)) begin
						cal_day++;
					end else if (cal_month < 12) begin
						cal_day = 1;
						cal_month++;
					end else if (cal_year >= YEAR_MAX) begin
						res.status = caldc_pkg::ST_LIMIT;
					end else begin
						cal_day = 1;
						cal_month = 1;
						cal_year++;
					end
					k++;
				end
			end
			caldc_pkg::OP_BACK: begin
				while (k < int'(r.count) && res.status == caldc_pkg::ST_OK) begin
					if (cal_day > 1) begin
						cal_day--;
					end else if (cal_month > 1) begin
						cal_month--;
						cal_day = month_length(cal_month, cal_year);
					end else if (cal_year == 0) begin
						res.status = caldc_pkg::ST_LIMIT;
					end else begin
						cal_year--;
						cal_month = 12;
						cal_day = 31;
					end
					k++;
				end
			end
			default: ;
		endcase
		res.day = 5'(cal_day);
		res.month = 4'(cal_month);
		res.year = YB'(cal_year);
		return res;
	endfunction

	function automatic void queue_request(caldc_pkg::op_t o, int d, int m, int y, int c);
		request_t r;
		r.op = o;
		r.day = 5'(d);
		r.month = 4'(m);
		r.year = YB'(y);
		r.count = CB'(c);
		pending_q.push_back(r);
	endfunction

	function automatic int random_span();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return $urandom_range(0, 40);
		if (pick < 93)
			return $urandom_range(0, 400);
		return $urandom_range(0, 2000);
	endfunction

	// Mostly a valid load followed by a few steps; the rest bad loads, unused opcodes and noise.
	function automatic int queue_random_sequence();
		int kind, y, m, d, len, n;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0: y = $urandom_range(1, 3);
			1: y = $urandom_range(YEAR_MAX - 3, YEAR_MAX);
			2: y = $urandom_range(1580, 2420);
			3: y = 100 * $urandom_range(1, YEAR_MAX / 100);
			4: y = 4 * $urandom_range(1, YEAR_MAX / 4);
			default: y = $urandom_range(1, YEAR_MAX);
		endcase
		m = $urandom_range(1, 12);
		len = month_length(m, y);
		if (kind < 60) begin
			d = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
			queue_request(caldc_pkg::OP_LOAD, d, m, y, $urandom_range(0, COUNT_MAX));
			n = $urandom_range(1, 4);
		end else if (kind < 80) begin
			case ($urandom_range(0, 2))
				0: queue_request(caldc_pkg::OP_LOAD, $urandom_range(0, 31),
					$urandom_range(0, 15), 0, $urandom_range(0, COUNT_MAX));
				1: queue_request(caldc_pkg::OP_LOAD, $urandom_range(0, 31),
					($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15), y,
					$urandom_range(0, COUNT_MAX));
				default: queue_request(caldc_pkg::OP_LOAD,
					(len == 31 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 31),
					m, y, $urandom_range(0, COUNT_MAX));
			endcase
			n = $urandom_range(0, 2);
		end else if (kind < 90) begin
			queue_request(caldc_pkg::OP_NONE, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, YEAR_MAX), $urandom_range(0, COUNT_MAX));
			return 0;
		end else begin
			queue_request(caldc_pkg::op_t'($urandom_range(0, 2)), $urandom_range(0, 31),
				$urandom_range(0, 15), $urandom_range(0, YEAR_MAX), random_span());
			return 1;
		end
		repeat (n)
			queue_request(($urandom_range(0, 1) == 0) ? caldc_pkg::OP_FWD : caldc_pkg::OP_BACK,
				$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, YEAR_MAX),
				random_span());
		return n + 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				date_q.push_back(advance_calendar(held_req));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 9);
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					held_req = pending_q.pop_front();
					in_valid <= 1'b1;
					op <= held_req.op;
					load_day <= held_req.day;
					load_month <= held_req.month;
					load_year <= held_req.year;
					step_count <= held_req.count;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_stall = $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		date_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (date_q.size() == 0) begin
				$error("result %0d/%0d/%0d status %0d with no request pending",
					cur_day, cur_month, cur_year, status);
				mismatches++;
			end else begin
				want = date_q.pop_front();
				if (cur_day !== want.day) begin
					$error("cur_day: expected %0d, actual %0d", want.day, cur_day);
					mismatches++;
				end
				if (cur_month !== want.month) begin
					$error("cur_month: expected %0d, actual %0d", want.month, cur_month);
					mismatches++;
				end
				if (cur_year !== want.year) begin
					$error("cur_year: expected %0d, actual %0d", want.year, cur_year);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int counted;
		queue_request(caldc_pkg::OP_FWD, 0, 0, 0, 0);
		queue_request(caldc_pkg::OP_NONE, 31, 15, YEAR_MAX, COUNT_MAX);
		queue_request(caldc_pkg::OP_LOAD, 1, 1, 1, 0);
		queue_request(caldc_pkg::OP_BACK, 0, 0, 0, 1);
		queue_request(caldc_pkg::OP_BACK, 0, 0, 0, 365);
		queue_request(caldc_pkg::OP_BACK, 0, 0, 0, 5);
		queue_request(caldc_pkg::OP_FWD, 0, 0, 0, 60);
		queue_request(caldc_pkg::OP_LOAD, 31, 12, 0, 0);
		queue_request(caldc_pkg::OP_LOAD, 31, 12, YEAR_MAX, 0);
		queue_request(caldc_pkg::OP_FWD, 0, 0, 0, 1);
		queue_request(caldc_pkg::OP_LOAD, 5, 0, 2000, 0);
		queue_request(caldc_pkg::OP_LOAD, 5, 15, 1900, 0);
		queue_request(caldc_pkg::OP_LOAD, 29, 2, 1900, 0);
		queue_request(caldc_pkg::OP_LOAD, 29, 2, 2000, 0);
		queue_request(caldc_pkg::OP_LOAD, 30, 2, 2000, 0);
		queue_request(caldc_pkg::OP_LOAD, 31, 4, 2024, 0);
		queue_request(caldc_pkg::OP_LOAD, 0, 6, 2023, 0);
		queue_request(caldc_pkg::OP_LOAD, 31, 1, 2023, 0);
		queue_request(caldc_pkg::OP_LOAD, 30, 2, 2024, 0);
		queue_request(caldc_pkg::OP_FWD, 0, 0, 0, 1);
		queue_request(caldc_pkg::OP_LOAD, 31, 1, 2100, 0);
		queue_request(caldc_pkg::OP_LOAD, 31, 2, 2100, 0);
		queue_request(caldc_pkg::OP_BACK, 0, 0, 0, 2);
		queue_request(caldc_pkg::OP_LOAD, 20, 12, YEAR_MAX, 0);
		queue_request(caldc_pkg::OP_FWD, 0, 0, 0, COUNT_MAX);
		queue_request(caldc_pkg::OP_LOAD, 1, 1, 1, 0);
		queue_request(caldc_pkg::OP_FWD, 0, 0, 0, COUNT_MAX);
		queue_request(caldc_pkg::OP_BACK, 0, 0, 0, COUNT_MAX);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk); while (pending_q.size() != 0 || in_valid || date_q.size() != 0);

		counted = 0;
		while (counted < 1150)
			counted += queue_random_sequence();
		do @(negedge clk); while (pending_q.size() != 0);
		calm = 1'b1;
		while (counted < 1300)
			counted += queue_random_sequence();

		do @(negedge clk); while (pending_q.size() != 0 || in_valid || date_q.size() != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
